// ----- design/psr_pkg.sv -----
// ----------------------------------------------------------------------------
// Per-bin running statistics: shared package
// Default parameter values, fixed field widths, mode codes and the control
// struct handed from the pipeline to the update logic.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int NBINS_DEF      = 256;
    localparam int VALUE_BITS_DEF = 16;

    localparam int BIN_W      = 9;
    localparam int COUNT_W    = 16;
    localparam int TOTAL_W    = 32;
    localparam int TOTAL_SQ_W = 47;
    localparam int PROFILE_W  = 16;

    localparam logic [COUNT_W-1:0]   COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [PROFILE_W-1:0] PROFILE_MAX = {PROFILE_W{1'b1}};

    typedef enum logic {
        MODE_ACCUM = 1'b0,
        MODE_READ  = 1'b1
    } t_mode;

    typedef struct packed {
        logic  valid;
        t_mode mode;
        logic  masked;
        logic  in_range;
    } t_ctl;

endpackage

// ----- design/per_bin_running_statistics.sv -----
// ----------------------------------------------------------------------------
// Per-bin running statistics
// Accumulates count, sum, sum of squares, minimum and maximum per bin, with
// the profile number at which each extreme was set.
// ----------------------------------------------------------------------------
// One sample is accepted per clock cycle while busy is low. Its result passes
// through the stage-1 registers and the output registers, is held on the output
// ports for one cycle and is marked by o_valid; the receiver cannot stall it.
// The pace is set by the bin memory's read-modify-write: the entry is read at
// acceptance, updated in the next cycle and written back, and a sample to the
// same bin as the one before it takes the freshly updated entry. After reset,
// busy stays high while the bin memory is cleared one entry per cycle.
// ----------------------------------------------------------------------------
module per_bin_running_statistics import psr_pkg::*; #(
    parameter int NBINS      = NBINS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_mode,
    input  logic [BIN_W-1:0]             i_bin,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_masked,
    input  logic                         i_last_of_profile,
    output logic                         o_valid,
    output logic [COUNT_W-1:0]           o_count,
    output logic signed [TOTAL_W-1:0]    o_total,
    output logic [TOTAL_SQ_W-1:0]        o_total_sq,
    output logic signed [VALUE_BITS-1:0] o_least,
    output logic signed [VALUE_BITS-1:0] o_greatest,
    output logic [PROFILE_W-1:0]         o_least_profile,
    output logic [PROFILE_W-1:0]         o_greatest_profile,
    output logic                         o_dropped
);

    localparam int ADDR_W  = (NBINS > 1) ? $clog2(NBINS) : 1;
    localparam int SQ_W    = 2 * VALUE_BITS;
    localparam int ENTRY_W = COUNT_W + TOTAL_W + TOTAL_SQ_W + 2 * VALUE_BITS + 2 * PROFILE_W;

    logic                         accept;
    logic                         in_range;
    logic signed [SQ_W-1:0]       n_sq;

    logic                         r_clearing;
    logic [ADDR_W-1:0]            r_clr_addr;
    logic [PROFILE_W-1:0]         r_profile;

    logic                         r_s1_valid;
    t_mode                        r_mode;
    logic                         r_masked;
    logic                         r_in_range;
    logic [ADDR_W-1:0]            r_addr;
    logic signed [VALUE_BITS-1:0] r_value;
    logic [TOTAL_SQ_W-1:0]        r_sq;
    logic [PROFILE_W-1:0]         r_prof;
    t_ctl                         s1_ctl;

    logic                         r_fwd_valid;
    logic [ADDR_W-1:0]            r_fwd_addr;
    logic [ENTRY_W-1:0]           r_fwd_data;

    logic [ENTRY_W-1:0]           ram_rdata;
    logic [ENTRY_W-1:0]           old_entry;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [ENTRY_W-1:0]           ram_wdata;

    logic                         upd_we;
    logic [ENTRY_W-1:0]           upd_wdata;
    logic [ENTRY_W-1:0]           reset_entry;
    logic [COUNT_W-1:0]           n_count;
    logic signed [TOTAL_W-1:0]    n_total;
    logic [TOTAL_SQ_W-1:0]        n_total_sq;
    logic signed [VALUE_BITS-1:0] n_least;
    logic signed [VALUE_BITS-1:0] n_greatest;
    logic [PROFILE_W-1:0]         n_least_profile;
    logic [PROFILE_W-1:0]         n_greatest_profile;
    logic                         n_dropped;

    assign busy     = r_clearing;
    assign accept   = start && !busy;
    assign in_range = (32'(i_bin) < 32'(NBINS));
    assign n_sq     = SQ_W'(i_value) * SQ_W'(i_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(NBINS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile <= '0;
        end else if (accept && (t_mode'(i_mode) == MODE_ACCUM) && i_last_of_profile
                     && (r_profile != PROFILE_MAX)) begin
            r_profile <= r_profile + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= t_mode'(i_mode);
        r_masked   <= i_masked;
        r_in_range <= in_range;
        r_addr     <= ADDR_W'(i_bin);
        r_value    <= i_value;
        r_sq       <= TOTAL_SQ_W'($unsigned(n_sq));
        r_prof     <= r_profile;
    end

    assign s1_ctl = '{valid: r_s1_valid, mode: r_mode, masked: r_masked,
                      in_range: r_in_range};

    psr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NBINS)
    ) u_psr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ADDR_W'(i_bin)),
        .o_rdata (ram_rdata)
    );

    assign old_entry = (r_fwd_valid && (r_fwd_addr == r_addr)) ? r_fwd_data : ram_rdata;

    psr_update #(
        .VALUE_BITS (VALUE_BITS)
    ) u_psr_update (
        .i_ctl              (s1_ctl),
        .i_old              (old_entry),
        .i_value            (r_value),
        .i_sq               (r_sq),
        .i_profile          (r_prof),
        .o_we               (upd_we),
        .o_wdata            (upd_wdata),
        .o_reset_entry      (reset_entry),
        .o_count            (n_count),
        .o_total            (n_total),
        .o_total_sq         (n_total_sq),
        .o_least            (n_least),
        .o_greatest         (n_greatest),
        .o_least_profile    (n_least_profile),
        .o_greatest_profile (n_greatest_profile),
        .o_dropped          (n_dropped)
    );

    assign ram_we    = r_clearing || upd_we;
    assign ram_waddr = r_clearing ? r_clr_addr : r_addr;
    assign ram_wdata = r_clearing ? reset_entry : upd_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= upd_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_addr;
        r_fwd_data <= upd_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_count            <= n_count;
        o_total            <= n_total;
        o_total_sq         <= n_total_sq;
        o_least            <= n_least;
        o_greatest         <= n_greatest;
        o_least_profile    <= n_least_profile;
        o_greatest_profile <= n_greatest_profile;
        o_dropped          <= n_dropped;
    end

endmodule

// ----- design/psr_ram.sv -----
// ----------------------------------------------------------------------------
// Per-bin running statistics: generic RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module psr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/psr_update.sv -----
// ----------------------------------------------------------------------------
// Per-bin running statistics: bin update
// Combines the stored entry of a bin with one sample and forms both the
// entry to write back and the fields to report.
// ----------------------------------------------------------------------------
module psr_update import psr_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  t_ctl                                    i_ctl,
    input  logic [COUNT_W+TOTAL_W+TOTAL_SQ_W+2*VALUE_BITS+2*PROFILE_W-1:0] i_old,
    input  logic signed [VALUE_BITS-1:0]            i_value,
    input  logic [TOTAL_SQ_W-1:0]                   i_sq,
    input  logic [PROFILE_W-1:0]                    i_profile,
    output logic                                    o_we,
    output logic [COUNT_W+TOTAL_W+TOTAL_SQ_W+2*VALUE_BITS+2*PROFILE_W-1:0] o_wdata,
    output logic [COUNT_W+TOTAL_W+TOTAL_SQ_W+2*VALUE_BITS+2*PROFILE_W-1:0] o_reset_entry,
    output logic [COUNT_W-1:0]                      o_count,
    output logic signed [TOTAL_W-1:0]               o_total,
    output logic [TOTAL_SQ_W-1:0]                   o_total_sq,
    output logic signed [VALUE_BITS-1:0]            o_least,
    output logic signed [VALUE_BITS-1:0]            o_greatest,
    output logic [PROFILE_W-1:0]                    o_least_profile,
    output logic [PROFILE_W-1:0]                    o_greatest_profile,
    output logic                                    o_dropped
);

    localparam logic signed [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic [COUNT_W-1:0]            old_count;
    logic signed [TOTAL_W-1:0]     old_total;
    logic [TOTAL_SQ_W-1:0]         old_sq;
    logic signed [VALUE_BITS-1:0]  old_least;
    logic signed [VALUE_BITS-1:0]  old_greatest;
    logic [PROFILE_W-1:0]          old_lprof;
    logic [PROFILE_W-1:0]          old_gprof;

    logic [COUNT_W-1:0]            new_count;
    logic signed [TOTAL_W-1:0]     new_total;
    logic [TOTAL_SQ_W-1:0]         new_sq;
    logic signed [VALUE_BITS-1:0]  new_least;
    logic signed [VALUE_BITS-1:0]  new_greatest;
    logic [PROFILE_W-1:0]          new_lprof;
    logic [PROFILE_W-1:0]          new_gprof;

    logic first;
    logic full;
    logic sample;
    logic take_min;
    logic take_max;

    assign {old_count, old_total, old_sq, old_least, old_greatest, old_lprof, old_gprof} = i_old;

    assign first    = (old_count == {COUNT_W{1'b0}});
    assign full     = (old_count == COUNT_MAX);
    assign sample   = (i_ctl.mode == MODE_ACCUM) && !i_ctl.masked;
    assign o_we     = i_ctl.valid && i_ctl.in_range && sample && !full;
    assign take_min = first || (i_value < old_least);
    assign take_max = first || (i_value > old_greatest);

    assign new_count    = COUNT_W'(old_count + 1'b1);
    assign new_total    = old_total + TOTAL_W'(i_value);
    assign new_sq       = old_sq + i_sq;
    assign new_least    = take_min ? i_value : old_least;
    assign new_greatest = take_max ? i_value : old_greatest;
    assign new_lprof    = take_min ? i_profile : old_lprof;
    assign new_gprof    = take_max ? i_profile : old_gprof;

    assign o_wdata = {new_count, new_total, new_sq, new_least, new_greatest,
                      new_lprof, new_gprof};

    assign o_reset_entry = {{COUNT_W{1'b0}}, {TOTAL_W{1'b0}}, {TOTAL_SQ_W{1'b0}},
                            MOST_POS, MOST_NEG, {PROFILE_W{1'b0}}, {PROFILE_W{1'b0}}};

    always_comb begin
        if (!i_ctl.in_range) begin
            o_count            = '0;
            o_total            = '0;
            o_total_sq         = '0;
            o_least            = '0;
            o_greatest         = '0;
            o_least_profile    = '0;
            o_greatest_profile = '0;
            o_dropped          = 1'b1;
        end else if (o_we) begin
            o_count            = new_count;
            o_total            = new_total;
            o_total_sq         = new_sq;
            o_least            = new_least;
            o_greatest         = new_greatest;
            o_least_profile    = new_lprof;
            o_greatest_profile = new_gprof;
            o_dropped          = 1'b0;
        end else begin
            o_count            = old_count;
            o_total            = old_total;
            o_total_sq         = old_sq;
            o_least            = old_least;
            o_greatest         = old_greatest;
            o_least_profile    = old_lprof;
            o_greatest_profile = old_gprof;
            o_dropped          = sample && full;
        end
    end

endmodule

// ----- design/psr_checker.sv -----
// ----------------------------------------------------------------------------
// Per-bin running statistics: port checker
// Watches the top level's ports for result timing, clearing after reset and
// the consistency of reported bins.
// ----------------------------------------------------------------------------
module psr_checker import psr_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [COUNT_W-1:0]           o_count,
    input logic signed [TOTAL_W-1:0]    o_total,
    input logic [TOTAL_SQ_W-1:0]        o_total_sq,
    input logic signed [VALUE_BITS-1:0] o_least,
    input logic signed [VALUE_BITS-1:0] o_greatest,
    input logic                         o_dropped
);

    // Every accepted beat is followed by a result marked by o_valid.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted beat produced no result");

    // The bin memory is being cleared right after reset.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    // A dropped beat that is not a full count is an out-of-range bin.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped && (o_count != COUNT_MAX)) |->
        (o_count == '0) && (o_total == '0) && (o_total_sq == '0)
        && (o_least == '0) && (o_greatest == '0))
        else $error("out-of-range result not cleared");

    // A bin holding samples has its minimum at or below its maximum.
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_dropped && (o_count != '0)) |-> (o_least <= o_greatest))
        else $error("bin minimum above maximum");

endmodule

bind per_bin_running_statistics psr_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_psr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_count    (o_count),
    .o_total    (o_total),
    .o_total_sq (o_total_sq),
    .o_least    (o_least),
    .o_greatest (o_greatest),
    .o_dropped  (o_dropped)
);

// ----- dv/per_bin_running_statistics_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-bin running statistics: self-checking testbench
// A directed table covers reset contents, out-of-range bins, masked samples,
// read mode, first samples and value extremes. A long random phase with idle
// bursts follows, and then a back-to-back run that keeps returning to one
// bin. Every result beat is checked against its table entry or a predictor.
// ----------------------------------------------------------------------------
module per_bin_running_statistics_test;
    import psr_pkg::*;

    localparam int  NB           = NBINS_DEF;
    localparam int  VB           = VALUE_BITS_DEF;
    localparam int  RANDOM_BEATS = 1500;
    localparam int  TAIL_BEATS   = 80;
    localparam int  HOT_BIN      = 254;
    localparam int  CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [COUNT_W-1:0]      count;
        logic signed [TOTAL_W-1:0] total;
        logic [TOTAL_SQ_W-1:0]   total_sq;
        logic signed [VB-1:0]    least;
        logic signed [VB-1:0]    greatest;
        logic [PROFILE_W-1:0]    least_prof;
        logic [PROFILE_W-1:0]    greatest_prof;
        logic                    dropped;
    } t_bin_report;

    typedef struct packed {
        t_mode                mode;
        logic [BIN_W-1:0]     bin;
        logic signed [VB-1:0] value;
        logic                 masked;
        logic                 last;
        logic                 typed;
        t_bin_report          want;
    } t_sample_row;

    localparam t_bin_report EMPTY_BIN = '{16'd0, 32'sd0, 47'd0, 16'sh7FFF, 16'sh8000,
                                          16'd0, 16'd0, 1'b0};
    localparam t_bin_report NO_BIN    = '{16'd0, 32'sd0, 47'd0, 16'sh0000, 16'sh0000,
                                          16'd0, 16'd0, 1'b1};

    localparam t_sample_row DIRECTED_ROWS [19] = '{
        '{MODE_READ,  9'd0,   16'sd0,      1'b0, 1'b0, 1'b1, EMPTY_BIN},
        '{MODE_READ,  9'd255, -16'sd1,     1'b0, 1'b1, 1'b1, EMPTY_BIN},
        '{MODE_ACCUM, 9'd511, 16'sd7,      1'b0, 1'b1, 1'b1, NO_BIN},
        '{MODE_READ,  9'd256, 16'sd0,      1'b0, 1'b0, 1'b1, NO_BIN},
        '{MODE_ACCUM, 9'd0,   16'sh7FFF,   1'b0, 1'b0, 1'b1,
          '{16'd1, 32'sd32767, 47'd1073676289, 16'sh7FFF, 16'sh7FFF, 16'd1, 16'd1, 1'b0}},
        '{MODE_ACCUM, 9'd0,   16'sh8000,   1'b0, 1'b0, 1'b0, EMPTY_BIN},
        '{MODE_ACCUM, 9'd0,   16'sd0,      1'b0, 1'b1, 1'b0, EMPTY_BIN},
        '{MODE_ACCUM, 9'd1,   16'sd5,      1'b1, 1'b1, 1'b1, EMPTY_BIN},
        '{MODE_ACCUM, 9'd1,   16'sd0,      1'b0, 1'b0, 1'b1,
          '{16'd1, 32'sd0, 47'd0, 16'sd0, 16'sd0, 16'd3, 16'd3, 1'b0}},
        '{MODE_ACCUM, 9'd1,   16'sd0,      1'b0, 1'b0, 1'b0, EMPTY_BIN},
        '{MODE_ACCUM, 9'd1,   -16'sd1,     1'b0, 1'b1, 1'b0, EMPTY_BIN},
        '{MODE_READ,  9'd1,   16'sd100,    1'b1, 1'b1, 1'b0, EMPTY_BIN},
        '{MODE_ACCUM, 9'd1,   16'sd1,      1'b0, 1'b0, 1'b0, EMPTY_BIN},
        '{MODE_ACCUM, 9'd2,   16'sh8000,   1'b0, 1'b0, 1'b1,
          '{16'd1, -32'sd32768, 47'd1073741824, 16'sh8000, 16'sh8000, 16'd4, 16'd4, 1'b0}},
        '{MODE_ACCUM, 9'd2,   16'sh8000,   1'b0, 1'b0, 1'b0, EMPTY_BIN},
        '{MODE_ACCUM, 9'd255, 16'shAAAA,   1'b0, 1'b1, 1'b0, EMPTY_BIN},
        '{MODE_ACCUM, 9'd255, 16'sh5555,   1'b0, 1'b0, 1'b0, EMPTY_BIN},
        '{MODE_ACCUM, 9'd256, -16'sd1,     1'b1, 1'b1, 1'b1, NO_BIN},
        '{MODE_READ,  9'd511, 16'sd0,      1'b0, 1'b0, 1'b1, NO_BIN}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_mode = 1'b0;
    logic [BIN_W-1:0]     i_bin = '0;
    logic signed [VB-1:0] i_value = '0;
    logic                 i_masked = 1'b0;
    logic                 i_last_of_profile = 1'b0;
    logic                 o_valid;
    logic [COUNT_W-1:0]   o_count;
    logic signed [TOTAL_W-1:0] o_total;
    logic [TOTAL_SQ_W-1:0] o_total_sq;
    logic signed [VB-1:0] o_least;
    logic signed [VB-1:0] o_greatest;
    logic [PROFILE_W-1:0] o_least_profile;
    logic [PROFILE_W-1:0] o_greatest_profile;
    logic                 o_dropped;

    logic                 beat_typed = 1'b0;
    t_bin_report          beat_want = EMPTY_BIN;

    logic [COUNT_W-1:0]      stat_count [NB];
    logic [TOTAL_W-1:0]      stat_total [NB];
    logic [TOTAL_SQ_W-1:0]   stat_total_sq [NB];
    logic signed [VB-1:0]    stat_least [NB];
    logic signed [VB-1:0]    stat_greatest [NB];
    logic [PROFILE_W-1:0]    stat_least_prof [NB];
    logic [PROFILE_W-1:0]    stat_greatest_prof [NB];
    logic [PROFILE_W-1:0]    profile_number = '0;

    t_bin_report pending_reports [$];
    int          fail_count = 0;
    int          cycle_count = 0;

    per_bin_running_statistics #(
        .NBINS      (NB),
        .VALUE_BITS (VB)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_bin              (i_bin),
        .i_value            (i_value),
        .i_masked           (i_masked),
        .i_last_of_profile  (i_last_of_profile),
        .o_valid            (o_valid),
        .o_count            (o_count),
        .o_total            (o_total),
        .o_total_sq         (o_total_sq),
        .o_least            (o_least),
        .o_greatest         (o_greatest),
        .o_least_profile    (o_least_profile),
        .o_greatest_profile (o_greatest_profile),
        .o_dropped          (o_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < NB; i++) begin
            stat_count[i]         = '0;
            stat_total[i]         = '0;
            stat_total_sq[i]      = '0;
            stat_least[i]         = 16'sh7FFF;
            stat_greatest[i]      = 16'sh8000;
            stat_least_prof[i]    = '0;
            stat_greatest_prof[i] = '0;
        end
    end

    // Applies one accepted sample to the shadow bin store and returns the
    // report that the block must produce for it.
    function automatic t_bin_report apply_sample(input logic mode, input logic [BIN_W-1:0] b,
                                                 input logic signed [VB-1:0] v,
                                                 input logic masked, input logic last);
        t_bin_report rep;
        longint      wide;
        logic        first;
        rep  = NO_BIN;
        wide = v;
        if (b < NB) begin
            rep.dropped = 1'b0;
            if (mode == MODE_ACCUM && !masked) begin
                if (stat_count[b] == COUNT_MAX) begin
                    rep.dropped = 1'b1;
                end else begin
                    first = (stat_count[b] == 0);
                    stat_count[b]    = stat_count[b] + 1'b1;
                    stat_total[b]    = stat_total[b] + TOTAL_W'(wide);
                    stat_total_sq[b] = stat_total_sq[b] + TOTAL_SQ_W'(wide * wide);
                    if (first || v < stat_least[b]) begin
                        stat_least[b]      = v;
                        stat_least_prof[b] = profile_number;
                    end
                    if (first || v > stat_greatest[b]) begin
                        stat_greatest[b]      = v;
                        stat_greatest_prof[b] = profile_number;
                    end
                end
            end
            rep.count         = stat_count[b];
            rep.total         = stat_total[b];
            rep.total_sq      = stat_total_sq[b];
            rep.least         = stat_least[b];
            rep.greatest      = stat_greatest[b];
            rep.least_prof    = stat_least_prof[b];
            rep.greatest_prof = stat_greatest_prof[b];
        end
        if (mode == MODE_ACCUM && last && profile_number != PROFILE_MAX)
            profile_number = profile_number + 1'b1;
        return rep;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_bin_report want;
        t_bin_report predicted;
        cycle_count <= cycle_count + 1;
        if (o_valid) begin
            if (pending_reports.size() == 0) begin
                fail_count++;
                $display("%0t: result beat with no expectation, count %0d",
                         $realtime, o_count);
            end else begin
                want = pending_reports.pop_front();
                check_field("count", want.count, o_count);
                check_field("total", want.total, o_total);
                check_field("total_sq", want.total_sq, o_total_sq);
                check_field("least", want.least, o_least);
                check_field("greatest", want.greatest, o_greatest);
                check_field("least_profile", want.least_prof, o_least_profile);
                check_field("greatest_profile", want.greatest_prof, o_greatest_profile);
                check_field("dropped", want.dropped, o_dropped);
            end
        end
        if (i_rst_n && start && !busy) begin
            predicted = apply_sample(i_mode, i_bin, i_value, i_masked, i_last_of_profile);
            pending_reports.push_back(beat_typed ? beat_want : predicted);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("per_bin_running_statistics_test NOT OK");
            $finish;
        end
    end

    task automatic send_sample(input t_sample_row s);
        @(negedge i_clk);
        start             <= 1'b1;
        i_mode            <= s.mode;
        i_bin             <= s.bin;
        i_value           <= s.value;
        i_masked          <= s.masked;
        i_last_of_profile <= s.last;
        beat_typed        <= s.typed;
        beat_want         <= s.want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    function automatic t_sample_row random_sample();
        t_sample_row s;
        int          pick;
        s       = '0;
        s.typed = 1'b0;
        s.want  = EMPTY_BIN;
        s.mode  = ($urandom_range(0, 9) == 0) ? MODE_READ : MODE_ACCUM;
        pick    = $urandom_range(0, 99);
        if (pick < 45)
            s.bin = BIN_W'($urandom_range(0, 7));
        else if (pick < 92)
            s.bin = BIN_W'($urandom_range(0, NB - 1));
        else
            s.bin = BIN_W'($urandom_range(NB, 511));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            s.value = 16'sh7FFF;
        else if (pick == 1)
            s.value = 16'sh8000;
        else if (pick < 4)
            s.value = VB'($signed($urandom_range(0, 64)) - 32);
        else
            s.value = VB'($urandom);
        s.masked = ($urandom_range(0, 9) == 0);
        s.last   = ($urandom_range(0, 4) == 0);
        return s;
    endfunction

    initial begin
        t_sample_row s;
        logic        idle_on;
        idle_on = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[k])
            send_sample(DIRECTED_ROWS[k]);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 64 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (n == RANDOM_BEATS / 2) begin
                @(negedge i_clk);
                start <= 1'b0;
                while (pending_reports.size() != 0) @(posedge i_clk);
            end
            if (idle_on && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 7));
            send_sample(random_sample());
        end

        // Back-to-back beats in which every other beat goes to one bin, so each update
        // of that bin must see the entry written by the previous beat to it.
        for (int n = 0; n < TAIL_BEATS; n++) begin
            s = random_sample();
            if (n % 2 == 0)
                s.bin = BIN_W'(HOT_BIN);
            send_sample(s);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0)
            $display("per_bin_running_statistics_test OK");
        else
            $display("per_bin_running_statistics_test NOT OK");
        $finish;
    end

endmodule
